// ===== src/wgm_pkg.sv =====
package wgm_pkg;

    // Pattern geometry.
    localparam int MAX_PATTERN_CHARS = 16;
    localparam int ROW_W             = MAX_PATTERN_CHARS + 1;
    localparam int LEN_W             = 5;
    localparam int CHARS_W           = 128;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 2;

    // Wildcard characters.
    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    // Queue between the classifying front and the row update.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHARS_LOW  = 2'd0,
        CFG_CHARS_HIGH = 2'd1,
        CFG_LENGTH     = 2'd2
    } wgm_cfg_idx_t;

    // One classified text byte: which pattern positions it satisfies directly.
    typedef struct packed {
        logic [MAX_PATTERN_CHARS-1:0] hit;
        logic                         last;
    } wgm_item_t;

    // Pattern information used by the row update.
    typedef struct packed {
        logic [MAX_PATTERN_CHARS-1:0] star;
        logic [LEN_W-1:0]             len;
    } wgm_pat_t;

    // Marks the pattern positions that hold a star.
    function automatic logic [MAX_PATTERN_CHARS-1:0] star_mask(input logic [CHARS_W-1:0] chars);
        logic [MAX_PATTERN_CHARS-1:0] mask;
        mask = '0;
        for (int k = 0; k < MAX_PATTERN_CHARS; k++) begin
            mask[k] = (chars[8*k +: 8] == STAR_CHAR);
        end
        return mask;
    endfunction

endpackage

// ===== src/wgm_front.sv =====
module wgm_front
    import wgm_pkg::*;
(
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         text_byte,
    input  logic               is_last_byte,
    input  logic [CHARS_W-1:0] chars,
    input  logic               queue_full,
    output logic               push,
    output wgm_item_t          push_item
);

    // Hold the sender off while the queue has no room.
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // Compare the byte against every pattern position at once.
    always_comb
    begin
        push_item.last = is_last_byte;
        for (int k = 0; k < MAX_PATTERN_CHARS; k++) begin
            push_item.hit[k] = (chars[8*k +: 8] == text_byte) ||
                               (chars[8*k +: 8] == ANY_CHAR);
        end
    end

endmodule

// ===== src/wgm_queue.sv =====
module wgm_queue
    import wgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  wgm_item_t push_item,
    input  logic      pop,
    output wgm_item_t pop_item,
    output logic      full,
    output logic      empty
);

    wgm_item_t              entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage words carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/wgm_back.sv =====
module wgm_back
    import wgm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      queue_empty,
    input  wgm_item_t item,
    output logic      pop,
    input  wgm_pat_t  pat,
    output logic      out_valid,
    input  logic      out_stall,
    output logic      matched
);

    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] init_row, prev_row;
    logic             start_reg;
    logic             out_valid_reg;
    logic             matched_reg, matched_next;
    logic [LEN_W-1:0] len_eff;
    logic             slot_free;

    // A word that gives no result never waits for the output register.
    assign slot_free = !out_valid_reg || !out_stall;
    assign pop       = !queue_empty && (slot_free || !item.last);

    // Row for an empty text: only leading stars can be passed.
    always_comb
    begin
        init_row    = '0;
        init_row[0] = 1'b1;
        for (int i = 1; i < ROW_W; i++) begin
            init_row[i] = pat.star[i-1] && init_row[i-1];
        end
    end

    assign prev_row = start_reg ? init_row : row_reg;

    // One text byte advances the row; a direct hit wins over the star rule.
    always_comb
    begin
        row_next    = '0;
        for (int i = 1; i < ROW_W; i++) begin
            if (item.hit[i-1]) begin
                row_next[i] = prev_row[i-1];
            end else if (pat.star[i-1]) begin
                row_next[i] = prev_row[i] || row_next[i-1];
            end else begin
                row_next[i] = 1'b0;
            end
        end
    end

    // Result bit at the configured length, clamped to the pattern size.
    always_comb
    begin
        if (pat.len > LEN_W'(MAX_PATTERN_CHARS)) begin
            len_eff = LEN_W'(MAX_PATTERN_CHARS);
        end else begin
            len_eff = pat.len;
        end
        matched_next = (len_eff != '0) && row_next[len_eff];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                start_reg <= item.last;
            end
            if (pop && item.last) begin
                out_valid_reg <= 1'b1;
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Row and result payload.
    always_ff @(posedge clk)
    begin
        if (pop) begin
            row_reg <= row_next;
        end
        if (pop && item.last) begin
            matched_reg <= matched_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule

// ===== src/wildcard_glob_matcher.sv =====
// Wildcard glob matcher. Text is streamed in one byte per word, the final byte
// of each text flagged by is_last_byte, and is matched case-sensitively against
// a pattern of up to 16 characters anchored at both ends: '?' stands for any
// one byte and '*' for any run, empty included. A text byte equal to '*' facing
// a '*' in the pattern counts as a direct match only. One word, matched, comes
// out for every last byte; a zero pattern length never matches and lengths
// above 16 act as 16. The block takes a byte every clock cycle while in_stall is
// low: the rate is set by the row update, which advances all pattern positions
// at once through a ripple of star positions. A last byte that is taken enters
// the queue, and the row update then loads its result word into the output
// register, held off while a stalled result word still waits there.
// Configuration writes must be made while no text is in flight.
module wildcard_glob_matcher
    import wgm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            text_byte,
    input  logic                  is_last_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  matched,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] chars_low_reg;
    logic [CFG_DATA_W-1:0] chars_high_reg;
    logic [LEN_W-1:0]      length_reg;
    logic [CHARS_W-1:0]    chars;
    wgm_pat_t              pat;
    wgm_item_t             push_item, pop_item;
    logic                  push, pop, queue_full, queue_empty;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            length_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                CFG_LENGTH:     length_reg     <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    assign chars    = {chars_high_reg, chars_low_reg};
    assign pat.star = star_mask(chars);
    assign pat.len  = length_reg;

    wgm_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .is_last_byte (is_last_byte),
        .chars        (chars),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item)
    );

    wgm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    wgm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .item        (pop_item),
        .pop         (pop),
        .pat         (pat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .matched     (matched)
    );

endmodule

// ===== src/wgm_checker.sv =====
module wgm_checker
    import wgm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  matched,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    logic len_zero_reg;

    // Shadow of whether the configured pattern is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_zero_reg <= 1'b1;
        end else if (cfg_we && (cfg_index == CFG_LENGTH)) begin
            len_zero_reg <= (cfg_data[LEN_W-1:0] == '0);
        end
    end

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(matched))
        else $error("stalled result changed or dropped");

    // An empty pattern never reports a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && len_zero_reg |-> !matched)
        else $error("match reported for an empty pattern");

    // The input side only fills up after taking a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stalled without a byte having been taken");

    // Leaving reset, nothing is pending and input is open.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("block not empty after reset");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wgm_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;
    localparam int IDLE_LIMIT    = 1000;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 70;

    // One row of the directed table: either a register write or a text byte.
    typedef struct {
        bit                    is_write;
        wgm_cfg_idx_t          reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [7:0]            b;
        logic                  last;
        bit                    typed;
        logic                  typed_val;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            text_byte = '0;
    logic                  is_last_byte = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  matched;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Pattern as the predictor sees it, and its own copy of the match row.
    logic [CHARS_W-1:0]    pat_chars = '0;
    logic [LEN_W-1:0]      pat_len = '0;
    logic [ROW_W-1:0]      glob_row = '0;
    bit                    row_fresh = 1'b1;

    logic                  due_matches[$];
    stim_row_t             directed_rows[$];
    logic [7:0]            text_q[$];
    logic [CHARS_W-1:0]    gen_chars;
    logic [LEN_W-1:0]      gen_len;

    int unsigned           fail_count = 0;
    int                    burst_left = 0;
    int                    no_gap_left = 0;
    bit                    hold_off_req = 1'b0;
    int                    idle_cycles = 0;

    wildcard_glob_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_byte    (text_byte),
        .is_last_byte (is_last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .matched      (matched),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Row at the start of a text: leading stars may already be satisfied.
    function automatic logic [ROW_W-1:0] start_row();
        logic [ROW_W-1:0] r;
        r = '0;
        r[0] = 1'b1;
        for (int i = 1; i <= MAX_PATTERN_CHARS; i++)
        begin
            if (pat_chars[8*(i-1) +: 8] == STAR_CHAR)
                r[i] = r[i-1];
        end
        return r;
    endfunction

    // One step of the glob recurrence; a direct hit takes precedence over a star.
    function automatic logic [ROW_W-1:0] advance_row(input logic [ROW_W-1:0] prev,
                                                     input logic [7:0] b);
        logic [ROW_W-1:0] r;
        logic [7:0]       c;
        r = '0;
        for (int i = 1; i <= MAX_PATTERN_CHARS; i++)
        begin
            c = pat_chars[8*(i-1) +: 8];
            if (c == b || c == ANY_CHAR)
                r[i] = prev[i-1];
            else if (c == STAR_CHAR)
                r[i] = prev[i] | r[i-1];
        end
        return r;
    endfunction

    // Advances the predicted row for an accepted byte and queues the verdict on a last byte.
    task automatic predict_byte(input logic [7:0] b, input logic last,
                                input bit typed, input logic typed_val);
        int   len;
        logic verdict;
        glob_row  = advance_row(row_fresh ? start_row() : glob_row, b);
        row_fresh = 1'b0;
        if (last)
        begin
            len = (pat_len > MAX_PATTERN_CHARS) ? MAX_PATTERN_CHARS : int'(pat_len);
            verdict = typed ? typed_val : ((len == 0) ? 1'b0 : glob_row[len]);
            due_matches = {due_matches, verdict};
            row_fresh = 1'b1;
        end
    endtask

    // Offers one text byte, opening a gap first when the current burst has run out.
    task automatic offer_byte(input logic [7:0] b, input logic last,
                              input bit typed, input logic typed_val);
        int gap;
        if (no_gap_left > 0)
            no_gap_left--;
        else if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
        end
        else
            burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        text_byte    <= b;
        is_last_byte <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_byte(b, last, typed, typed_val);
    endtask

    // Stops offering and waits until every verdict is in and the pipeline is empty.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input wgm_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_CHARS_LOW:  pat_chars[63:0]   = val;
            CFG_CHARS_HIGH: pat_chars[127:64] = val;
            CFG_LENGTH:     pat_len           = val[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic dir_write(input wgm_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r = '{1'b1, idx, val, 8'h00, 1'b0, 1'b0, 1'b0};
        directed_rows = {directed_rows, r};
    endtask

    task automatic dir_byte(input logic [7:0] b, input logic last,
                            input bit typed, input logic typed_val);
        stim_row_t r;
        r = '{1'b0, CFG_CHARS_LOW, '0, b, last, typed, typed_val};
        directed_rows = {directed_rows, r};
    endtask

    // Pattern characters are drawn mostly from a small alphabet so that texts often match.
    function automatic logic [7:0] pattern_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h61 + 8'($urandom_range(0, 2));
            3, 4:    return ANY_CHAR;
            5, 6:    return STAR_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 5))
            0:       return 8'h61;
            1:       return 8'h62;
            2:       return 8'h63;
            3:       return STAR_CHAR;
            4:       return ANY_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds one text: mostly derived from the pattern, sometimes spoilt or unrelated.
    task automatic build_text();
        int         n;
        int         mode;
        int         pos;
        logic [7:0] c;
        text_q.delete();
        mode = $urandom_range(0, 9);
        if (mode <= 7)
        begin
            n = (gen_len > MAX_PATTERN_CHARS) ? MAX_PATTERN_CHARS : int'(gen_len);
            for (int k = 0; k < n; k++)
            begin
                c = gen_chars[8*k +: 8];
                if (c == ANY_CHAR)
                    text_q = {text_q, 8'($urandom_range(0, 255))};
                else if (c == STAR_CHAR)
                    repeat ($urandom_range(0, 3)) text_q = {text_q, text_char()};
                else
                    text_q = {text_q, c};
            end
        end
        else
        begin
            repeat ($urandom_range(1, 10)) text_q = {text_q, text_char()};
        end
        if (text_q.size() == 0)
            text_q = {text_q, text_char()};
        // Spoil a derived text by changing one byte or dropping the tail.
        if (mode == 6)
        begin
            pos = $urandom_range(0, text_q.size() - 1);
            text_q[pos] = text_q[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (mode == 7 && text_q.size() > 1)
            void'(text_q.pop_back());
    endtask

    // One random phase: a fresh pattern, then texts until the phase's share of bytes is sent.
    task automatic random_phase(input bit hold_off);
        int                    sent;
        logic [CFG_DATA_W-1:0] len_word;
        settle_block();
        if ($urandom_range(0, 7) == 0)
            gen_chars = {$urandom, $urandom, $urandom, $urandom};
        else
        begin
            for (int k = 0; k < MAX_PATTERN_CHARS; k++)
                gen_chars[8*k +: 8] = pattern_char();
        end
        case ($urandom_range(0, 15))
            0:       gen_len = '0;
            1:       gen_len = LEN_W'($urandom_range(17, 31));
            2, 3:    gen_len = LEN_W'($urandom_range(9, 16));
            default: gen_len = LEN_W'($urandom_range(1, 8));
        endcase
        // Upper bits of the length word are random; only the low bits are significant.
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = gen_len;
        write_reg(CFG_CHARS_LOW, gen_chars[63:0]);
        write_reg(CFG_CHARS_HIGH, gen_chars[127:64]);
        write_reg(CFG_LENGTH, len_word);
        if (hold_off)
        begin
            hold_off_req = 1'b1;
            no_gap_left  = 48;
        end
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            build_text();
            foreach (text_q[k])
                offer_byte(text_q[k], k == text_q.size() - 1, 1'b0, 1'b0);
            sent += text_q.size();
        end
    endtask

    // Receiver: changing stall patterns, plus a long hold-off when the sender asks for one.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 2) == 0);
                    2:       out_stall <= (mode_left % 4 == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Each verdict word is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_matches.size() == 0)
            begin
                $error("matched: no result expected, got %0b", matched);
                fail_count++;
            end
            else
            begin
                if (matched !== due_matches[0])
                begin
                    $error("matched: expected %0b, got %0b", due_matches[0], matched);
                    fail_count++;
                end
                void'(due_matches.pop_front());
            end
        end
    end

    // Watchdog: too long without any word moving on either side means a hang.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("wildcard_glob_matcher verification failed");
            $finish;
        end
    end

    initial
    begin : sender
        bit prev_write;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty pattern after reset never matches.
        dir_byte(8'h61, 1'b1, 1'b1, 1'b0);
        dir_byte(8'hFF, 1'b1, 1'b1, 1'b0);
        // Pattern "a?c*".
        dir_write(CFG_CHARS_LOW, 64'h0000_0000_2A63_3F61);
        dir_write(CFG_CHARS_HIGH, 64'h0);
        dir_write(CFG_LENGTH, 64'd4);
        dir_byte(8'h61, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h62, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h63, 1'b1, 1'b1, 1'b1);
        dir_byte(8'h61, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h5A, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h63, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h78, 1'b1, 1'b0, 1'b0);
        dir_byte(8'h41, 1'b1, 1'b0, 1'b0);
        // Pattern "*b": a literal star in the text only takes the diagonal.
        dir_write(CFG_CHARS_LOW, 64'h622A);
        dir_write(CFG_LENGTH, 64'd2);
        dir_byte(STAR_CHAR, 1'b0, 1'b0, 1'b0);
        dir_byte(STAR_CHAR, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h62, 1'b1, 1'b0, 1'b0);
        dir_byte(8'h78, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h62, 1'b1, 1'b0, 1'b0);
        // Zero length overrides a usable pattern.
        dir_write(CFG_LENGTH, 64'd0);
        dir_byte(8'h62, 1'b1, 1'b1, 1'b0);
        // Pattern swapped from "ab" to "?c" in the middle of a text.
        dir_write(CFG_CHARS_LOW, 64'h6261);
        dir_write(CFG_LENGTH, 64'd2);
        dir_byte(8'h61, 1'b0, 1'b0, 1'b0);
        dir_write(CFG_CHARS_LOW, 64'h633F);
        dir_byte(8'h63, 1'b1, 1'b0, 1'b0);
        // All stars, with an oversized length and then the full length.
        dir_write(CFG_CHARS_LOW, 64'h2A2A_2A2A_2A2A_2A2A);
        dir_write(CFG_CHARS_HIGH, 64'h2A2A_2A2A_2A2A_2A2A);
        dir_write(CFG_LENGTH, 64'd31);
        dir_byte(8'h00, 1'b1, 1'b1, 1'b1);
        dir_write(CFG_LENGTH, 64'd16);
        dir_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        dir_byte(8'h55, 1'b1, 1'b1, 1'b1);
        // All-ones characters: the first one is the byte 0xFF.
        dir_write(CFG_CHARS_LOW, '1);
        dir_write(CFG_CHARS_HIGH, '1);
        dir_write(CFG_LENGTH, 64'd1);
        dir_byte(8'hFF, 1'b1, 1'b1, 1'b1);
        dir_byte(8'hFE, 1'b1, 1'b1, 1'b0);

        // Walk the table; writes only go in once the block has gone quiet.
        prev_write = 1'b1;
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].is_write)
            begin
                if (!prev_write)
                    settle_block();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end
            else
                offer_byte(directed_rows[k].b, directed_rows[k].last,
                           directed_rows[k].typed, directed_rows[k].typed_val);
            prev_write = directed_rows[k].is_write;
        end

        for (int p = 0; p < NUM_PHASES; p++)
            random_phase(p == 3 || p == 8);

        settle_block();
        if (fail_count == 0)
            $display("wildcard_glob_matcher verification clean");
        else
            $display("wildcard_glob_matcher verification failed");
        $finish;
    end

endmodule
